FILE: design/mct_pkg.sv
// shared constants and types for the macd crossover trader
package mct_pkg;

    localparam int PRICE_WIDTH_DEF = 32;
    localparam int CASH_W          = 48;
    localparam int POS_W           = 17;
    localparam int ALPHA_W         = 16;
    localparam int LIMIT_W         = 16;
    localparam int CFG_IDX_W       = 4;
    localparam int MUL_B_W         = POS_W;

    localparam logic [ALPHA_W-1:0] SHORT_ALPHA_RST  = 16'd10082;
    localparam logic [ALPHA_W-1:0] LONG_ALPHA_RST   = 16'd4855;
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd13107;
    localparam logic [LIMIT_W-1:0] POS_LIMIT_RST    = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ALPHA  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ALPHA   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ALPHA = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT    = 4'd3;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

endpackage

FILE: design/macd_crossover_trader_unit.sv
// top level of the macd crossover trader
// One price word in, one result word out. From acceptance to the result handshake a
// sample passes through the short, long and signal average updates, each of which
// needs one pass through a single two-stage multiplier, then the trade decision; a final
// sample adds the position times price pass of the profit. The first sample
// after reset only seeds the averages and skips their updates. The block takes one
// sample at a time; s_tready is high only while it waits for a sample.
module macd_crossover_trader_unit import mct_pkg::*; #(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((PRICE_WIDTH+7)/8)*8-1:0]      s_tdata,   // price_sample
    input  logic                                  s_tlast,   // last_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*CASH_W+POS_W+7)/8)*8-1:0]   m_tdata,   // cash_balance, held_position, final_profit
    output logic [2:0]                            m_tuser,   // trade_action, profit_valid
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [ALPHA_W-1:0]                    cfg_data
);

    localparam int AVG_W    = PRICE_WIDTH;
    localparam int SIG_W    = PRICE_WIDTH + 1;
    localparam int DIF_W    = PRICE_WIDTH + 2;
    localparam int PROD_W   = DIF_W + MUL_B_W;
    localparam int SUM_W    = ((PROD_W > CASH_W) ? PROD_W : CASH_W) + 1;
    localparam int CSUM_W   = CASH_W + 2;
    localparam int M_DATA_W = ((2*CASH_W+POS_W+7)/8)*8;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SHORT = 13'b0000000000010,
        ST_LONG  = 13'b0000000000100,
        ST_SHUPD = 13'b0000000001000,
        ST_LGUPD = 13'b0000000010000,
        ST_SIG   = 13'b0000000100000,
        ST_SWAIT = 13'b0000001000000,
        ST_SGUPD = 13'b0000010000000,
        ST_DEC   = 13'b0000100000000,
        ST_PROF  = 13'b0001000000000,
        ST_PWAIT = 13'b0010000000000,
        ST_PUPD  = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ALPHA_W-1:0]       short_alpha_reg, long_alpha_reg, signal_alpha_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [AVG_W-1:0]         price_reg;
    logic                     last_reg;
    logic                     seeded_reg;
    logic [AVG_W-1:0]         short_reg, long_reg;
    logic signed [SIG_W-1:0]  macd_reg, signal_reg;
    logic signed [CASH_W-1:0] cash_reg, profit_reg;
    logic signed [POS_W-1:0]  pos_reg;
    action_t                  action_reg;

    logic signed [DIF_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [DIF_W-1:0]   ema_step;
    logic [DIF_W-1:0]          short_sum, long_sum;
    logic [AVG_W-1:0]          long_new;
    logic signed [SIG_W-1:0]   macd_new;
    logic signed [POS_W:0]     pos_ext, lim_ext;
    logic                      buy_ok, sell_ok;
    logic signed [CSUM_W-1:0]  cash_buy, cash_sell;
    logic signed [CASH_W-1:0]  cash_buy_sat, cash_sell_sat;
    logic signed [SUM_W-1:0]   profit_sum;
    logic signed [CASH_W-1:0]  profit_sat;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SHORT: begin
                mul_a = $signed({2'b00, price_reg}) - $signed({2'b00, short_reg});
                mul_b = $signed({1'b0, short_alpha_reg});
            end
            ST_LONG: begin
                mul_a = $signed({2'b00, price_reg}) - $signed({2'b00, long_reg});
                mul_b = $signed({1'b0, long_alpha_reg});
            end
            ST_SIG: begin
                mul_a = $signed({macd_reg[SIG_W-1], macd_reg})
                      - $signed({signal_reg[SIG_W-1], signal_reg});
                mul_b = $signed({1'b0, signal_alpha_reg});
            end
            ST_PROF: begin
                mul_a = $signed({2'b00, price_reg});
                mul_b = pos_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mct_mul #(
        .A_W (DIF_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    // floor of product over 2^16
    assign ema_step  = product[ALPHA_W +: DIF_W];
    assign short_sum = {2'b00, short_reg} + ema_step;
    assign long_sum  = {2'b00, long_reg} + ema_step;
    assign long_new  = long_sum[AVG_W-1:0];
    assign macd_new  = $signed({1'b0, short_reg}) - $signed({1'b0, long_new});

    assign pos_ext = {pos_reg[POS_W-1], pos_reg};
    assign lim_ext = $signed({1'b0, limit_reg[LIMIT_W-1:0]}) ;
    assign buy_ok  = (macd_reg > signal_reg) && (pos_ext < lim_ext);
    assign sell_ok = (macd_reg < signal_reg) && (pos_ext > -lim_ext);

    assign cash_buy  = $signed({{2{cash_reg[CASH_W-1]}}, cash_reg})
                     - $signed({{(CSUM_W-AVG_W){1'b0}}, price_reg});
    assign cash_sell = $signed({{2{cash_reg[CASH_W-1]}}, cash_reg})
                     + $signed({{(CSUM_W-AVG_W){1'b0}}, price_reg});

    // saturate to the cash range
    always_comb begin
        cash_buy_sat = cash_buy[CASH_W-1:0];
        if (!cash_buy[CSUM_W-1] && (|cash_buy[CSUM_W-1:CASH_W-1])) begin
            cash_buy_sat = {1'b0, {(CASH_W-1){1'b1}}};
        end else if (cash_buy[CSUM_W-1] && !(&cash_buy[CSUM_W-1:CASH_W-1])) begin
            cash_buy_sat = {1'b1, {(CASH_W-1){1'b0}}};
        end
        cash_sell_sat = cash_sell[CASH_W-1:0];
        if (!cash_sell[CSUM_W-1] && (|cash_sell[CSUM_W-1:CASH_W-1])) begin
            cash_sell_sat = {1'b0, {(CASH_W-1){1'b1}}};
        end else if (cash_sell[CSUM_W-1] && !(&cash_sell[CSUM_W-1:CASH_W-1])) begin
            cash_sell_sat = {1'b1, {(CASH_W-1){1'b0}}};
        end
    end

    assign profit_sum = $signed({{(SUM_W-CASH_W){cash_reg[CASH_W-1]}}, cash_reg})
                      + $signed({{(SUM_W-PROD_W){product[PROD_W-1]}}, product});

    always_comb begin
        profit_sat = profit_sum[CASH_W-1:0];
        if (!profit_sum[SUM_W-1] && (|profit_sum[SUM_W-1:CASH_W-1])) begin
            profit_sat = {1'b0, {(CASH_W-1){1'b1}}};
        end else if (profit_sum[SUM_W-1] && !(&profit_sum[SUM_W-1:CASH_W-1])) begin
            profit_sat = {1'b1, {(CASH_W-1){1'b0}}};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = seeded_reg ? ST_SHORT : ST_DEC;
                end
            end
            ST_SHORT: state_next = ST_LONG;
            ST_LONG:  state_next = ST_SHUPD;
            ST_SHUPD: state_next = ST_LGUPD;
            ST_LGUPD: state_next = ST_SIG;
            ST_SIG:   state_next = ST_SWAIT;
            ST_SWAIT: state_next = ST_SGUPD;
            ST_SGUPD: state_next = ST_DEC;
            ST_DEC:   state_next = last_reg ? ST_PROF : ST_DONE;
            ST_PROF:  state_next = ST_PWAIT;
            ST_PWAIT: state_next = ST_PUPD;
            ST_PUPD:  state_next = ST_DONE;
            ST_DONE: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            short_alpha_reg  <= SHORT_ALPHA_RST;
            long_alpha_reg   <= LONG_ALPHA_RST;
            signal_alpha_reg <= SIGNAL_ALPHA_RST;
            limit_reg        <= POS_LIMIT_RST;
            seeded_reg       <= 1'b0;
            short_reg        <= '0;
            long_reg         <= '0;
            signal_reg       <= '0;
            macd_reg         <= '0;
            cash_reg         <= '0;
            pos_reg          <= '0;
            action_reg       <= ACT_HOLD;
            profit_reg       <= '0;
            last_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SHORT_ALPHA:  short_alpha_reg  <= cfg_data;
                    REG_LONG_ALPHA:   long_alpha_reg   <= cfg_data;
                    REG_SIGNAL_ALPHA: signal_alpha_reg <= cfg_data;
                    REG_POS_LIMIT:    limit_reg        <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        last_reg <= s_tlast;
                        if (!seeded_reg) begin
                            short_reg  <= s_tdata[AVG_W-1:0];
                            long_reg   <= s_tdata[AVG_W-1:0];
                            signal_reg <= '0;
                            macd_reg   <= '0;
                            seeded_reg <= 1'b1;
                        end
                    end
                end
                ST_SHUPD: short_reg <= short_sum[AVG_W-1:0];
                ST_LGUPD: begin
                    long_reg <= long_new;
                    macd_reg <= macd_new;
                end
                ST_SGUPD: signal_reg <= signal_reg + ema_step[SIG_W-1:0];
                ST_DEC: begin
                    profit_reg <= '0;
                    if (buy_ok) begin
                        cash_reg   <= cash_buy_sat;
                        pos_reg    <= pos_reg + POS_W'(1);
                        action_reg <= ACT_BUY;
                    end else if (sell_ok) begin
                        cash_reg   <= cash_sell_sat;
                        pos_reg    <= pos_reg - POS_W'(1);
                        action_reg <= ACT_SELL;
                    end else begin
                        action_reg <= ACT_HOLD;
                    end
                end
                ST_PUPD: profit_reg <= profit_sat;
                default: ;
            endcase
        end
    end

    // price word is payload, captured without reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            price_reg <= s_tdata[AVG_W-1:0];
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_DONE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(M_DATA_W-2*CASH_W-POS_W){1'b0}}, profit_reg, pos_reg, cash_reg};
    assign m_tuser   = {last_reg, action_reg};

endmodule

FILE: design/mct_mul.sv
// shared signed multiplier with registered operands and registered product
module mct_mul import mct_pkg::*; #(
    parameter int A_W = PRICE_WIDTH_DEF + 2,
    parameter int B_W = MUL_B_W
) (
    input  logic                      aclk,
    input  logic signed [A_W-1:0]     op_a,
    input  logic signed [B_W-1:0]     op_b,
    output logic signed [A_W+B_W-1:0] product
);

    logic signed [A_W-1:0]     a_reg;
    logic signed [B_W-1:0]     b_reg;
    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        a_reg    <= op_a;
        b_reg    <= op_b;
        prod_reg <= a_reg * b_reg;
    end

    assign product = prod_reg;

endmodule

FILE: dv/macd_crossover_trader_unit_tb.sv
// self-checking testbench for the macd crossover trader: directed table, random price walks
module macd_crossover_trader_unit_tb;
    import mct_pkg::*;

    localparam int PRICE_W     = PRICE_WIDTH_DEF;
    localparam int S_W         = ((PRICE_W + 7) / 8) * 8;
    localparam int M_W         = ((2 * CASH_W + POS_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int WORDS_PER_PHASE = 100;
    localparam int DIRECTED_ROWS   = 18;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
    localparam longint SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO    = -SAT_HI - 1;
    localparam longint PRICE_TOP = 64'sh0000_0000_FFFF_FFFF;

    typedef struct packed {
        action_t                  act;
        logic signed [CASH_W-1:0] cash;
        logic signed [POS_W-1:0]  pos;
        logic signed [CASH_W-1:0] profit;
        logic                     valid;
    } trade_result_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last;
        logic               typed;
        trade_result_t      known;
    } price_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_W-1:0]       m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ALPHA_W-1:0]   cfg_data;

    // predictor state
    logic [ALPHA_W-1:0] short_w   = SHORT_ALPHA_RST;
    logic [ALPHA_W-1:0] long_w    = LONG_ALPHA_RST;
    logic [ALPHA_W-1:0] signal_w  = SIGNAL_ALPHA_RST;
    logic [LIMIT_W-1:0] limit_units = POS_LIMIT_RST;
    longint short_avg  = 0;
    longint long_avg   = 0;
    longint signal_avg = 0;
    longint cash_bal   = 0;
    int     held_units = 0;
    bit     avg_seeded = 1'b0;

    trade_result_t expected_trades[$];
    logic          row_typed;
    trade_result_t row_known;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            mismatch_count = 0;
    int            cycle_count    = 0;

    longint walk_level = 64'sh0000_0000_0100_0000;
    int     walk_step  = 0;
    int     walk_left  = 0;
    bit     walk_up    = 1'b1;

    logic [ALPHA_W-1:0] phase_short [PHASES] =
        '{SHORT_ALPHA_RST, 16'd65535, 16'd20000, 16'd10082, 16'd0, 16'd30000, 16'd1, 16'd12000};
    logic [ALPHA_W-1:0] phase_long [PHASES] =
        '{LONG_ALPHA_RST, 16'd65535, 16'd3000, 16'd4855, 16'd0, 16'd1, 16'd65535, 16'd6000};
    logic [ALPHA_W-1:0] phase_signal [PHASES] =
        '{SIGNAL_ALPHA_RST, 16'd65535, 16'd16000, 16'd13107, 16'd0, 16'd65535, 16'd5000,
          16'd20000};
    logic [LIMIT_W-1:0] phase_limit [PHASES] =
        '{POS_LIMIT_RST, 16'd65535, 16'd40, 16'd2, 16'd0, 16'd0, 16'd7, 16'd65535};

    // first rows seed the averages on a flat price, so they can only hold
    price_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0001_0000, 1'b0, 1'b1, '{ACT_HOLD, 48'sd0, 17'sd0, 48'sd0, 1'b0}},
        '{32'h0001_0000, 1'b0, 1'b1, '{ACT_HOLD, 48'sd0, 17'sd0, 48'sd0, 1'b0}},
        '{32'h0001_0000, 1'b1, 1'b1, '{ACT_HOLD, 48'sd0, 17'sd0, 48'sd0, 1'b1}},
        '{32'h0002_0000, 1'b0, 1'b0, '0},
        '{32'h0004_0000, 1'b0, 1'b0, '0},
        '{32'h0008_0000, 1'b0, 1'b0, '0},
        '{32'h0010_0000, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h0100_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b1, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, 1'b0, '0},
        '{32'h0000_FFFF, 1'b1, 1'b0, '0}
    };

    macd_crossover_trader_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint ema_next(longint avg, longint x, logic [ALPHA_W-1:0] a);
        logic signed [81:0] diff;
        logic signed [81:0] prod;
        diff = x - avg;
        prod = diff * $signed({66'd0, a});
        return avg + longint'(prod >>> 16);
    endfunction

    function automatic longint sat48(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic trade_result_t predict_trade(logic [PRICE_W-1:0] price, logic last);
        trade_result_t r;
        longint px;
        longint macd;
        longint profit;
        int     lim;
        px = {32'd0, price};
        lim = int'(limit_units);
        profit = 0;
        r.act = ACT_HOLD;
        if (!avg_seeded) begin
            short_avg  = px;
            long_avg   = px;
            signal_avg = 0;
            avg_seeded = 1'b1;
            macd = 0;
        end else begin
            short_avg  = ema_next(short_avg, px, short_w);
            long_avg   = ema_next(long_avg, px, long_w);
            macd       = short_avg - long_avg;
            signal_avg = ema_next(signal_avg, macd, signal_w);
        end
        if (macd > signal_avg && held_units < lim) begin
            cash_bal = sat48(cash_bal - px);
            held_units++;
            r.act = ACT_BUY;
        end else if (macd < signal_avg && held_units > -lim) begin
            cash_bal = sat48(cash_bal + px);
            held_units--;
            r.act = ACT_SELL;
        end
        if (last) profit = sat48(cash_bal + longint'(held_units) * px);
        r.cash   = cash_bal[CASH_W-1:0];
        r.pos    = held_units[POS_W-1:0];
        r.profit = profit[CASH_W-1:0];
        r.valid  = last;
        return r;
    endfunction

    // trending segments with random step sizes, some jumps and some pure noise
    function automatic logic [PRICE_W-1:0] next_price();
        if ($urandom_range(9) == 0) return $urandom;
        if (walk_left == 0) begin
            if ($urandom_range(7) == 0) walk_level = longint'($urandom);
            walk_up   = 1'($urandom_range(1));
            walk_step = $urandom_range(1 << $urandom_range(24, 4)) + 1;
            walk_left = $urandom_range(40, 3);
        end
        walk_left--;
        walk_level += walk_up ? walk_step : -walk_step;
        if (walk_level < 0) walk_level = 0;
        else if (walk_level > PRICE_TOP) walk_level = PRICE_TOP;
        return walk_level[PRICE_W-1:0];
    endfunction

    task automatic send_word(input logic [PRICE_W-1:0] price, input logic last,
                             input logic typed, input trade_result_t known);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata   = price;
        s_tlast   = last;
        row_typed = typed;
        row_known = known;
        s_tvalid  = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results(input int settle);
        while (expected_trades.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL macd_crossover_trader_unit");
            $finish;
        end
    end

    always @(posedge aclk) begin
        trade_result_t want;
        trade_result_t got;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SHORT_ALPHA:  short_w = cfg_data;
                REG_LONG_ALPHA:   long_w = cfg_data;
                REG_SIGNAL_ALPHA: signal_w = cfg_data;
                REG_POS_LIMIT:    limit_units = cfg_data;
                default: ;
            endcase
        end
        if (s_tvalid && s_tready) begin
            want = predict_trade(s_tdata[PRICE_W-1:0], s_tlast);
            if (row_typed) want = row_known;
            expected_trades = {expected_trades, want};
        end
        if (m_tvalid && m_tready) begin
            got.act    = action_t'(m_tuser[1:0]);
            got.valid  = m_tuser[2];
            got.cash   = m_tdata[CASH_W-1:0];
            got.pos    = m_tdata[CASH_W+POS_W-1:CASH_W];
            got.profit = m_tdata[2*CASH_W+POS_W-1:CASH_W+POS_W];
            if (expected_trades.size() == 0) begin
                $error("result word with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_trades.pop_front();
                if (got.act !== want.act) begin
                    $error("trade_action: expected %0d, got %0d", want.act, got.act);
                    mismatch_count++;
                end
                if (got.cash !== want.cash) begin
                    $error("cash_balance: expected %0d, got %0d", want.cash, got.cash);
                    mismatch_count++;
                end
                if (got.pos !== want.pos) begin
                    $error("held_position: expected %0d, got %0d", want.pos, got.pos);
                    mismatch_count++;
                end
                if (got.profit !== want.profit) begin
                    $error("final_profit: expected %0d, got %0d", want.profit, got.profit);
                    mismatch_count++;
                end
                if (got.valid !== want.valid) begin
                    $error("profit_valid: expected %0d, got %0d", want.valid, got.valid);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int p;
        int i;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SHORT_ALPHA;
        cfg_data  = '0;
        row_typed = 1'b0;
        row_known = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                s_tvalid = 1'b0;
                drain_results(16);
                write_reg(REG_UNUSED, ALPHA_W'($urandom));
                write_reg(REG_SHORT_ALPHA, phase_short[p]);
                write_reg(REG_LONG_ALPHA, phase_long[p]);
                write_reg(REG_SIGNAL_ALPHA, phase_signal[p]);
                write_reg(REG_POS_LIMIT, phase_limit[p]);
            end
            send_idle_pct  = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 33 : 0;
            recv_stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 33 : 0;
            if (p == 0) begin
                for (i = 0; i < DIRECTED_ROWS; i++)
                    send_word(directed_rows[i].price, directed_rows[i].last,
                              directed_rows[i].typed, directed_rows[i].known);
            end
            for (i = 0; i < WORDS_PER_PHASE; i++)
                send_word(next_price(), $urandom_range(15) == 0, 1'b0, '0);
        end
        s_tvalid = 1'b0;
        drain_results(40);

        if (mismatch_count == 0) begin
            $display("PASS macd_crossover_trader_unit");
        end else begin
            $display("FAIL macd_crossover_trader_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mct_pkg.sv
design/mct_mul.sv
design/macd_crossover_trader_unit.sv
dv/macd_crossover_trader_unit_tb.sv
